### rtl/cfml_pkg.sv
// Shared types, constants and helpers for the CIDR first-match lookup block.
// No dependencies; cfml_scan, the top level and the checker use this package.
`default_nettype none

package cfml_pkg;

  localparam int unsigned ADDR_W      = 32;  // IPv4 address
  localparam int unsigned PREFIX_W    = 6;   // prefix length field
  localparam int unsigned ENTRY_IDX_W = 8;   // slot / match index field
  localparam int unsigned LOC_FIELD_W = 16;  // location id field
  localparam int unsigned CFG_W       = 9;   // entries_in_use register

  // stream payload widths (zero padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 24;

  // input tdata field positions
  localparam int unsigned IN_IDX_LSB  = 0;
  localparam int unsigned IN_BASE_LSB = IN_IDX_LSB + ENTRY_IDX_W;
  localparam int unsigned IN_PREF_LSB = IN_BASE_LSB + ADDR_W;
  localparam int unsigned IN_LOC_LSB  = IN_PREF_LSB + PREFIX_W;
  localparam int unsigned IN_ADDR_LSB = IN_LOC_LSB + LOC_FIELD_W;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } cfml_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } cfml_state_e;

  typedef struct packed {
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] index;
    logic [LOC_FIELD_W-1:0] location;
  } cfml_res_t;

  // Address lies in [base, base | host mask]. Prefix 0 covers up to all ones,
  // prefix 32 and above covers only the base.
  function automatic logic in_range(input logic [ADDR_W-1:0]   addr,
                                    input logic [ADDR_W-1:0]   base,
                                    input logic [PREFIX_W-1:0] prefix);
    logic [ADDR_W-1:0] host_mask;
    logic [ADDR_W-1:0] hi;
    if (prefix >= PREFIX_W'(ADDR_W)) begin
      host_mask = '0;
    end else begin
      host_mask = {ADDR_W{1'b1}} >> prefix[4:0];
    end
    hi = base | host_mask;
    return (addr >= base) && (addr <= hi);
  endfunction

endpackage

`default_nettype wire

### rtl/cfml_table.sv
// Entry table: single-port-write, single-port-read synchronous RAM
// with a registered read port. Depends on nothing.
`default_nettype none

module cfml_table #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 54
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/cfml_scan.sv
// Sequencer: accepts items, writes entries, scans the table one entry per
// cycle and holds the result register. Depends on cfml_pkg.
`default_nettype none

module cfml_scan #(
  parameter int unsigned AW = 8,
  parameter int unsigned CW = 9,
  parameter int unsigned LW = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // item side
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     in_op_i,
  input  wire logic                     in_slot_ok_i,
  input  wire logic [AW-1:0]            in_wr_addr_i,
  input  wire logic [LW+37:0]           in_wr_data_i,
  input  wire logic [cfml_pkg::ADDR_W-1:0] in_addr_i,
  input  wire logic [CW-1:0]            count_i,
  // table
  output logic                          wr_en_o,
  output logic      [AW-1:0]            wr_addr_o,
  output logic      [LW+37:0]           wr_data_o,
  output logic                          rd_en_o,
  output logic      [AW-1:0]            rd_addr_o,
  input  wire logic [LW+37:0]           rd_data_i,
  // result side
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output cfml_pkg::cfml_res_t           out_res_o
);

  import cfml_pkg::*;

  cfml_state_e       state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_idx_q;
  logic [ADDR_W-1:0] addr_q;
  cfml_res_t         pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  cfml_res_t         out_q;

  logic              accept;
  logic              match_now;
  logic              scan_done;
  logic              out_free;
  logic [ADDR_W-1:0] rd_base;
  logic [PREFIX_W-1:0] rd_pref;
  logic [LW-1:0]     rd_loc;

  assign rd_base = rd_data_i[ADDR_W-1:0];
  assign rd_pref = rd_data_i[ADDR_W+PREFIX_W-1:ADDR_W];
  assign rd_loc  = rd_data_i[LW+37:ADDR_W+PREFIX_W];

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign match_now = rd_vld_q && in_range(addr_q, rd_base, rd_pref);
  assign scan_done = (cnt_q == count_i);
  assign out_free  = !out_vld_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_WRITE || count_i == '0) begin
            state_d = ST_HOLD;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match_now || scan_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          pend_d = '0;
          if (in_op_i == OP_WRITE) begin
            wr_en_o = in_slot_ok_i;
          end else if (count_i != '0) begin
            rd_en_o = 1'b1;
            cnt_d   = CW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (match_now) begin
          pend_d.hit      = 1'b1;
          pend_d.index    = ENTRY_IDX_W'(rd_idx_q);
          pend_d.location = LOC_FIELD_W'(rd_loc);
        end else if (scan_done) begin
          pend_d = '0;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_addr_o = in_wr_addr_i;
  assign wr_data_o = in_wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en_o;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (rd_en_o) begin
      rd_idx_q <= rd_addr_o;
    end
    if (accept) begin
      addr_q <= in_addr_i;
    end
    if (state_q == ST_HOLD && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

### rtl/cidr_first_match_lookup.sv
// Top level of the CIDR first-match lookup: stream ports, count register,
// entry table and scan sequencer. Depends on cfml_pkg, cfml_table, cfml_scan.
//
// Usage:
//   Input stream (s_axis_*): one transfer is one item. tuser carries the
//   opcode (write entry / look up address); tdata carries the entry fields
//   and the lookup address. Every item yields exactly one result transfer
//   on m_axis_*: tuser = hit, tdata = {match_location, match_index}.
//   Writes and misses return hit = 0 and zero data.
//   Config channel (cfg_*): always ready, sets entries_in_use (9 bits); the
//   count searched is min(entries_in_use, TABLE_DEPTH). Write it while idle.
// Sequencing:
//   One item is in flight at a time. A write passes from the idle state
//   through the hold state into the output register. A lookup reads one
//   entry per cycle through the single RAM read port, from entry 0 up, and
//   stops at the first hit or after the last searched entry; the next item
//   is taken right after the result has moved into the output register.
// Reset: clears the sequencer, output valid and entries_in_use (0). The table
//   RAM is not cleared; entries must be written before they are searched.
// Stall: the output register holds its result while m_axis_tready_i is low;
//   the block finishes the next item and then waits in front of it.
`default_nettype none

module cidr_first_match_lookup #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned LOCATION_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // item stream in
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [7:0] entry_index, [39:8] entry_base, [45:40] entry_prefix_len,
  // [61:46] entry_location, [93:62] lookup_address, [95:94] zero
  input  wire logic [cfml_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] opcode
  input  wire logic [0:0]                         s_axis_tuser_i,
  // result stream out
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] match_index, [23:8] match_location
  output logic      [cfml_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] hit
  output logic      [0:0]                         m_axis_tuser_o,
  // entries_in_use write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cfml_pkg::CFG_W-1:0]         cfg_data_i
);

  import cfml_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  // stored location width; the field itself is only 16 bits wide
  localparam int unsigned LW = (LOCATION_BITS < LOC_FIELD_W) ? LOCATION_BITS
                                                             : LOC_FIELD_W;
  localparam int unsigned DW = LW + ADDR_W + PREFIX_W;

  logic [CFG_W-1:0] entries_q;

  // item fields
  logic [ENTRY_IDX_W-1:0] in_idx;
  logic [ADDR_W-1:0]      in_base;
  logic [PREFIX_W-1:0]    in_pref;
  logic [LOC_FIELD_W-1:0] in_loc;
  logic [ADDR_W-1:0]      in_addr;
  logic                   slot_ok;
  logic [CW-1:0]          count;
  logic [DW-1:0]          wr_word;

  // table port
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;

  cfml_res_t res;

  assign in_idx  = s_axis_tdata_i[IN_IDX_LSB  +: ENTRY_IDX_W];
  assign in_base = s_axis_tdata_i[IN_BASE_LSB +: ADDR_W];
  assign in_pref = s_axis_tdata_i[IN_PREF_LSB +: PREFIX_W];
  assign in_loc  = s_axis_tdata_i[IN_LOC_LSB  +: LOC_FIELD_W];
  assign in_addr = s_axis_tdata_i[IN_ADDR_LSB +: ADDR_W];

  // writes beyond the table are dropped
  assign slot_ok = 32'(in_idx) < 32'(TABLE_DEPTH);
  assign wr_word = {in_loc[LW-1:0], in_pref, in_base};

  // search count saturates at the table depth
  assign count = (32'(entries_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                     : CW'(entries_q);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i) begin
      entries_q <= cfg_data_i;
    end
  end

  cfml_table #(
    .AW (AW),
    .DW (DW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cfml_scan #(
    .AW (AW),
    .CW (CW),
    .LW (LW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (s_axis_tuser_i[0]),
    .in_slot_ok_i (slot_ok),
    .in_wr_addr_i (AW'(in_idx)),
    .in_wr_data_i (wr_word),
    .in_addr_i    (in_addr),
    .count_i      (count),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (res)
  );

  assign m_axis_tdata_o = {res.location, res.index};
  assign m_axis_tuser_o = res.hit;

endmodule

`default_nettype wire

### rtl/cfml_checker.sv
// Port-level checks for cidr_first_match_lookup, attached by bind.
// Depends on cfml_pkg.
`default_nettype none

module cfml_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [cfml_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [0:0]                      m_axis_tuser_o,
  input wire logic                            cfg_ready_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // writes and misses carry zero index and location
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("non-hit result with nonzero data");

  // one item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while busy");

  // config channel is ready once reset is released
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> cfg_ready_o)
    else $error("config channel not ready after reset");

endmodule

bind cidr_first_match_lookup cfml_checker u_cfml_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .cfg_ready_o     (cfg_ready_o)
);

`default_nettype wire
